// ----- sv/bpcm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpcm_pkg
// Shared constants, register codes and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package bpcm_pkg;

   localparam int MAX_SYMBOL_BITS_DEFAULT = 7;
   localparam int WORD_BITS_DEFAULT       = 16;
   localparam int MIN_SYMBOL_BITS         = 2;

   localparam int TABLE_DEPTH  = 128;
   localparam int TABLE_AW     = 7;
   localparam int ENTRY_W      = 16;
   localparam int BYTE_W       = 8;
   localparam int SAMPLE_W     = 16;
   localparam int GAIN_W       = 16;
   localparam int PROD_W       = BYTE_W + GAIN_W;
   localparam int BPS_W        = 3;

   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_BITS_PER_SYMBOL = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_SCALE_GAIN      = 1'b1;

   localparam logic [BPS_W-1:0]  BPS_RESET  = 3'd2;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd1;

   typedef struct packed {
      logic load_word;
      logic write_table;
      logic read_sym;
      logic load_out;
   } bpcm_cmd_type;

   typedef struct packed {
      logic out_free;
      logic last_symbol;
   } bpcm_status_type;

endpackage
`default_nettype wire

// ----- sv/bpcm_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpcm_req_if
// Request channel: data words and table write commands.
// ----------------------------------------------------------------------------
interface bpcm_req_if #(
   parameter int WORD_BITS = bpcm_pkg::WORD_BITS_DEFAULT
);
   logic                                valid;
   logic                                ready;
   logic                                command;
   logic [WORD_BITS-1:0]                data_word;
   logic                                restart;
   logic [bpcm_pkg::TABLE_AW-1:0]       table_index;
   logic [bpcm_pkg::ENTRY_W-1:0]        table_value;

   modport source (output valid, command, data_word, restart, table_index, table_value,
                   input ready);
   modport sink   (input valid, command, data_word, restart, table_index, table_value,
                   output ready);
endinterface
`default_nettype wire

// ----- sv/bpcm_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpcm_rsp_if
// Response channel: one mapped constellation point per request symbol.
// ----------------------------------------------------------------------------
interface bpcm_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [bpcm_pkg::SAMPLE_W-1:0] in_phase;
   logic signed [bpcm_pkg::SAMPLE_W-1:0] quadrature;
   logic                                 last_of_word;

   modport source (output valid, in_phase, quadrature, last_of_word, input ready);
   modport sink   (input valid, in_phase, quadrature, last_of_word, output ready);
endinterface
`default_nettype wire

// ----- sv/bpcm_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpcm_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bpcm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ----- sv/bpcm_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpcm_ctrl
// Sequencer: accept a request, then read and map a data word symbol by symbol.
// ----------------------------------------------------------------------------
module bpcm_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   input  wire logic                      req_command,
   input  wire bpcm_pkg::bpcm_status_type status,
   output logic                           req_ready,
   output bpcm_pkg::bpcm_cmd_type         cmd
);
   import bpcm_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_MULT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_command) begin
                  cmd.write_table = 1'b1;
               end else begin
                  cmd.load_word = 1'b1;
                  state_in      = ST_READ;
               end
            end
         end
         ST_READ: begin
            cmd.read_sym = 1'b1;
            state_in     = ST_MULT;
         end
         ST_MULT: begin
            // hold until the output register frees up
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = status.last_symbol ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

// ----- sv/bpcm_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpcm_datapath
// Bit reservoir, symbol extraction, constellation table and gain multipliers.
// ----------------------------------------------------------------------------
module bpcm_datapath #(
   parameter int MAX_SYMBOL_BITS = bpcm_pkg::MAX_SYMBOL_BITS_DEFAULT,
   parameter int WORD_BITS       = bpcm_pkg::WORD_BITS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire bpcm_pkg::bpcm_cmd_type             cmd,
   output bpcm_pkg::bpcm_status_type               status,
   input  wire logic                               csr_write_enable,
   input  wire logic [bpcm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [bpcm_pkg::CSR_DATA_W-1:0]    csr_write_data,
   input  wire logic [WORD_BITS-1:0]               data_word,
   input  wire logic                               restart,
   input  wire logic [bpcm_pkg::TABLE_AW-1:0]      table_index,
   input  wire logic [bpcm_pkg::ENTRY_W-1:0]       table_value,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic signed [bpcm_pkg::SAMPLE_W-1:0]    rsp_in_phase,
   output logic signed [bpcm_pkg::SAMPLE_W-1:0]    rsp_quadrature,
   output logic                                    rsp_last_of_word
);
   import bpcm_pkg::*;

   localparam int RES_W  = WORD_BITS + MAX_SYMBOL_BITS - 1;
   localparam int HELD_W = $clog2(WORD_BITS + MAX_SYMBOL_BITS);
   localparam int SYM_W  = MAX_SYMBOL_BITS;

   logic [BPS_W-1:0]         bps_ff;
   logic signed [GAIN_W-1:0] gain_ff;
   logic [RES_W-1:0]         reservoir_ff, reservoir_in;
   logic [HELD_W-1:0]        held_ff, held_in;
   logic                     last_ff, last_in;
   logic                     rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] in_phase_ff, quadrature_ff;
   logic                     out_last_ff;

   logic [HELD_W-1:0]        bps_wide;
   logic [HELD_W-1:0]        sym_bits;
   logic [HELD_W-1:0]        held_base;
   logic [HELD_W-1:0]        held_after;
   logic [RES_W-1:0]         shifted;
   logic [SYM_W-1:0]         sym_mask;
   logic [SYM_W-1:0]         sym;
   logic [ENTRY_W-1:0]       entry;
   logic signed [BYTE_W-1:0] byte_i, byte_q;
   logic signed [PROD_W-1:0] prod_i, prod_q;

   // clamp the symbol size to the supported range
   always_comb begin
      bps_wide = HELD_W'(bps_ff);
      if (bps_wide < HELD_W'(MIN_SYMBOL_BITS)) begin
         sym_bits = HELD_W'(MIN_SYMBOL_BITS);
      end else if (bps_wide > HELD_W'(MAX_SYMBOL_BITS)) begin
         sym_bits = HELD_W'(MAX_SYMBOL_BITS);
      end else begin
         sym_bits = bps_wide;
      end
   end

   assign held_base  = restart ? '0 : held_ff;
   assign held_after = held_ff - sym_bits;
   assign shifted    = reservoir_ff >> held_after;
   assign sym_mask   = ~({SYM_W{1'b1}} << sym_bits);
   assign sym        = shifted[SYM_W-1:0] & sym_mask;

   always_comb begin
      reservoir_in = reservoir_ff;
      held_in      = held_ff;
      last_in      = last_ff;
      if (cmd.load_word) begin
         // stale bits above the held count are never selected
         reservoir_in = {reservoir_ff[RES_W-WORD_BITS-1:0], data_word};
         held_in      = held_base + HELD_W'(WORD_BITS);
      end else if (cmd.read_sym) begin
         held_in = held_after;
         last_in = (held_after < sym_bits);
      end
   end

   bpcm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.write_table),
      .wr_addr (table_index),
      .wr_data (table_value),
      .rd_en   (cmd.read_sym),
      .rd_addr (TABLE_AW'(sym)),
      .rd_data (entry)
   );

   assign byte_i = entry[ENTRY_W-1:BYTE_W];
   assign byte_q = entry[BYTE_W-1:0];
   assign prod_i = byte_i * gain_ff;
   assign prod_q = byte_q * gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bps_ff       <= BPS_RESET;
         gain_ff      <= GAIN_RESET;
         reservoir_ff <= '0;
         held_ff      <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               REG_BITS_PER_SYMBOL: bps_ff  <= csr_write_data[BPS_W-1:0];
               REG_SCALE_GAIN:      gain_ff <= csr_write_data[GAIN_W-1:0];
               default: begin
               end
            endcase
         end
         reservoir_ff <= reservoir_in;
         held_ff      <= held_in;
         last_ff      <= last_in;
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         in_phase_ff   <= prod_i[SAMPLE_W-1:0];
         quadrature_ff <= prod_q[SAMPLE_W-1:0];
         out_last_ff   <= last_ff;
      end
   end

   assign status.out_free    = ~rsp_valid_ff | rsp_ready;
   assign status.last_symbol = last_ff;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_in_phase     = in_phase_ff;
   assign rsp_quadrature   = quadrature_ff;
   assign rsp_last_of_word = out_last_ff;
endmodule
`default_nettype wire

// ----- sv/bit_packer_constellation_mapper.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bit_packer_constellation_mapper
// Cuts data words into symbols and maps each through a constellation table.
// ----------------------------------------------------------------------------
// Usage:
//  - req_if carries requests: command 0 maps data_word (MSB first) into
//    symbols of bits_per_symbol bits (at least 2); command 1 writes
//    table_value to constellation entry table_index. Leftover bits carry
//    into the next word unless restart is set.
//  - rsp_if returns one point per symbol: signed entry bytes times
//    scale_gain, wrapped to 16 bits; last_of_word flags the final symbol.
//  - csr_* writes bits_per_symbol (index 0) and scale_gain (index 1); write
//    only while the block is idle.
//  - A table write leaves the block idle, ready for the next request. A data
//    word is taken, then each symbol takes a table read and then a multiply
//    into the output register, which waits while that register is full. The
//    registered table read port is why read and multiply are separate steps.
//  - Reset clears the carried bits and sets bits_per_symbol to 2 and
//    scale_gain to 1; table contents stay undefined until written.
//  - When rsp_ready is low the output register holds the point and mapping
//    stalls; after the final point of a word is loaded the next request is
//    accepted even while that point waits.
// ----------------------------------------------------------------------------
module bit_packer_constellation_mapper #(
   parameter int MAX_SYMBOL_BITS = bpcm_pkg::MAX_SYMBOL_BITS_DEFAULT,
   parameter int WORD_BITS       = bpcm_pkg::WORD_BITS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   bpcm_req_if.sink                              req_if,
   bpcm_rsp_if.source                            rsp_if,
   input  wire logic                             csr_write_enable,
   input  wire logic [bpcm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [bpcm_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import bpcm_pkg::*;

   bpcm_cmd_type    cmd;
   bpcm_status_type status;
   logic            req_ready;

   // sequence the request and the symbols of a word
   bpcm_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_command (req_if.command),
      .status      (status),
      .req_ready   (req_ready),
      .cmd         (cmd)
   );

   // hold the reservoir, table, gain and output register
   bpcm_datapath #(
      .MAX_SYMBOL_BITS (MAX_SYMBOL_BITS),
      .WORD_BITS       (WORD_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .data_word        (req_if.data_word),
      .restart          (req_if.restart),
      .table_index      (req_if.table_index),
      .table_value      (req_if.table_value),
      .rsp_valid        (rsp_if.valid),
      .rsp_ready        (rsp_if.ready),
      .rsp_in_phase     (rsp_if.in_phase),
      .rsp_quadrature   (rsp_if.quadrature),
      .rsp_last_of_word (rsp_if.last_of_word)
   );

   assign req_if.ready = req_ready;
endmodule
`default_nettype wire

// ----- sim/bpcm_tb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpcm_tb_pkg
// Request codes and the mapped point record shared by the testbench files.
// ----------------------------------------------------------------------------
package bpcm_tb_pkg;

   localparam logic CMD_MAP_WORD    = 1'b0;
   localparam logic CMD_TABLE_WRITE = 1'b1;

   typedef struct packed {
      logic signed [15:0] in_phase;
      logic signed [15:0] quadrature;
      logic               last_of_word;
   } map_point_type;

endpackage

// ----- sim/symbol_map_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symbol_map_checker
// Watches the request, response and CSR ports, predicts the mapped points of
// each accepted data word and compares every response in order.
// ----------------------------------------------------------------------------
module symbol_map_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   bpcm_req_if                                   req_mon,
   bpcm_rsp_if                                   rsp_mon,
   input  wire logic                             csr_write_enable,
   input  wire logic [bpcm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [bpcm_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output int                                    failures,
   output int                                    outstanding
);
   import bpcm_pkg::*;
   import bpcm_tb_pkg::*;

   logic [BPS_W-1:0]   symbol_bits;
   logic [GAIN_W-1:0]  gain;
   logic [21:0]        carry_bits;
   int                 carry_count;
   logic [ENTRY_W-1:0] point_table [TABLE_DEPTH];
   map_point_type      point_q [$];
   map_point_type      want;

   function automatic logic [15:0] scale_byte(input logic [7:0] value,
                                              input logic [15:0] g);
      logic signed [7:0]  s_value;
      logic signed [15:0] s_gain;
      int                 product;
      s_value = value;
      s_gain  = g;
      product = s_value * s_gain;
      return product[15:0];
   endfunction

   // Append the word to the carried bits and queue one point per full symbol.
   task automatic map_word(input logic [15:0] word, input logic restart);
      logic [37:0]        acc;
      logic [6:0]         sym;
      logic [ENTRY_W-1:0] entry;
      int                 n;
      int                 held;
      map_point_type      pt;
      if (restart) begin
         carry_bits  = '0;
         carry_count = 0;
      end
      n = (symbol_bits < MIN_SYMBOL_BITS) ? MIN_SYMBOL_BITS : int'(symbol_bits);
      if (n > MAX_SYMBOL_BITS_DEFAULT) n = MAX_SYMBOL_BITS_DEFAULT;
      acc  = {carry_bits, word};
      held = carry_count + 16;
      while (held >= n) begin
         held -= n;
         sym = 7'((acc >> held) & ((38'd1 << n) - 38'd1));
         entry = point_table[sym];
         pt.in_phase     = scale_byte(entry[15:8], gain);
         pt.quadrature   = scale_byte(entry[7:0], gain);
         pt.last_of_word = (held < n);
         point_q.push_back(pt);
      end
      carry_bits  = 22'(acc & ((38'd1 << held) - 38'd1));
      carry_count = held;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         symbol_bits = BPS_RESET;
         gain        = GAIN_RESET;
         carry_bits  = '0;
         carry_count = 0;
         failures    = 0;
         point_q.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               REG_BITS_PER_SYMBOL: symbol_bits = csr_write_data[BPS_W-1:0];
               REG_SCALE_GAIN:      gain = csr_write_data[GAIN_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.command == CMD_TABLE_WRITE)
               point_table[req_mon.table_index] = req_mon.table_value;
            else
               map_word(req_mon.data_word, req_mon.restart);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (point_q.size() == 0) begin
               $error("unexpected point: in_phase %0d, quadrature %0d, last %0b",
                      rsp_mon.in_phase, rsp_mon.quadrature, rsp_mon.last_of_word);
               failures++;
            end else begin
               want = point_q.pop_front();
               if (rsp_mon.in_phase !== want.in_phase) begin
                  $error("in_phase: expected %0d, got %0d",
                         want.in_phase, rsp_mon.in_phase);
                  failures++;
               end
               if (rsp_mon.quadrature !== want.quadrature) begin
                  $error("quadrature: expected %0d, got %0d",
                         want.quadrature, rsp_mon.quadrature);
                  failures++;
               end
               if (rsp_mon.last_of_word !== want.last_of_word) begin
                  $error("last_of_word: expected %0b, got %0b",
                         want.last_of_word, rsp_mon.last_of_word);
                  failures++;
               end
            end
         end
      end
      outstanding <= point_q.size();
   end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives table loads and data words into the bit packer / constellation
// mapper under several symbol sizes and gains, with random gaps on both
// channels; the checker beside the block predicts and compares every point.
// ----------------------------------------------------------------------------
module tb;
   import bpcm_pkg::*;
   import bpcm_tb_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 24;   // settle time after the last point drains
   localparam int PHASES       = 6;
   localparam int PHASE_ITEMS  = 20;
   localparam int IDLE_PERCENT = 9;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic steady = 1'b0;   // high: neither side idles

   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   int failures;
   int outstanding;
   int cycle_count = 0;

   bpcm_req_if req_if ();
   bpcm_rsp_if rsp_if ();

   bit_packer_constellation_mapper u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_if),
      .rsp_if           (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   symbol_map_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_if),
      .rsp_mon          (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .failures         (failures),
      .outstanding      (outstanding)
   );

   always #1 clock = ~clock;

   // Stall the response side at random, except through the steady stretch.
   always @(posedge clock) begin
      rsp_if.ready <= steady ? 1'b1 : ($urandom_range(99) >= IDLE_PERCENT);
   end

   // Guard against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   // Present one request, with optional idle cycles ahead of it, and hold it
   // until the block takes it. Valid stays high into the next request.
   task automatic send_request(input logic cmd, input logic [15:0] word,
                               input logic restart, input logic [6:0] index,
                               input logic [15:0] value);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.command     <= cmd;
      req_if.data_word   <= word;
      req_if.restart     <= restart;
      req_if.table_index <= index;
      req_if.table_value <= value;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
   endtask

   // Data word request; the table fields carry noise the block must ignore.
   task automatic push_word(input logic [15:0] word, input logic restart);
      send_request(CMD_MAP_WORD, word, restart, 7'($urandom), 16'($urandom));
   endtask

   // Table write request; word and restart carry noise.
   task automatic push_entry(input logic [6:0] index, input logic [15:0] value);
      send_request(CMD_TABLE_WRITE, 16'($urandom), 1'($urandom), index, value);
   endtask

   // Drop valid, drain every pending point, then let a trailing table write
   // finish before the CSRs are touched.
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (HOLD_CYCLES) @(posedge clock);
   endtask

   // Write both registers; the upper bits of the symbol size write are noise.
   task automatic configure(input logic [BPS_W-1:0] bits, input logic [GAIN_W-1:0] g);
      csr_write_enable <= 1'b1;
      csr_index        <= REG_BITS_PER_SYMBOL;
      csr_write_data   <= {13'($urandom), bits};
      @(posedge clock);
      csr_index        <= REG_SCALE_GAIN;
      csr_write_data   <= g;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int          r;
      logic [15:0] g;
      logic [15:0] word;

      req_if.valid       = 1'b0;
      req_if.command     = CMD_MAP_WORD;
      req_if.data_word   = '0;
      req_if.restart     = 1'b0;
      req_if.table_index = '0;
      req_if.table_value = '0;
      rsp_if.ready       = 1'b0;
      csr_write_enable   = 1'b0;
      csr_index          = REG_BITS_PER_SYMBOL;
      csr_write_data     = '0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Load the whole table so no symbol can ever hit an unwritten entry.
      for (int i = 0; i < TABLE_DEPTH; i++) push_entry(7'(i), 16'($urandom));

      // Reset settings: 2-bit symbols, unit gain. All-zero and all-one words,
      // then a word whose leftovers carry (none at this size).
      push_word(16'h0000, 1'b1);
      push_word(16'hffff, 1'b0);
      push_word(16'h8001, 1'b0);

      // Symbol size below the minimum acts as 2; largest positive gain.
      wait_idle();
      configure(3'd0, 16'h7fff);
      push_word(16'ha5a5, 1'b0);

      // Extreme table entries on the four 2-bit symbols and the top entry.
      push_entry(7'd0, 16'h807f);
      push_entry(7'd1, 16'h7f7f);
      push_entry(7'd2, 16'h0000);
      push_entry(7'd3, 16'h7f80);
      push_entry(7'd127, 16'h8080);

      // Size of 1 also clamps; most negative gain.
      wait_idle();
      configure(3'd1, 16'h8000);
      push_word(16'h1b1b, 1'b1);

      // Largest symbol size with gain -1: leftovers carry across words and a
      // restart drops them.
      wait_idle();
      configure(3'd7, 16'hffff);
      push_word(16'hffff, 1'b1);
      push_word(16'h0000, 1'b0);
      push_word(16'h0001, 1'b1);
      push_word(16'hfe01, 1'b0);

      // Zero gain; a table write between words leaves the carried bits alone.
      wait_idle();
      configure(3'd3, 16'h0000);
      push_word(16'h5555, 1'b0);
      push_entry(7'd5, 16'h1234);
      push_word(16'haaaa, 1'b0);

      wait_idle();
      configure(3'd5, 16'h7fff);
      push_word(16'($urandom), 1'b1);
      push_word(16'hffff, 1'b0);

      // Random phases: fresh settings each time, mostly data words with
      // occasional restarts and table rewrites. Hold the third phase steady.
      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         case ($urandom_range(3))
            0:       g = 16'h8000;
            1:       g = 16'h7fff;
            default: g = 16'($urandom);
         endcase
         configure(3'($urandom_range(7)), g);
         steady <= (p == 2);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            r = $urandom_range(99);
            if (r < 15) begin
               push_entry(7'($urandom), 16'($urandom));
            end else begin
               if (r < 20)      word = 16'hffff;
               else if (r < 24) word = 16'h0000;
               else             word = 16'($urandom);
               push_word(word, $urandom_range(9) == 0);
            end
         end
      end

      // Drain and give the verdict.
      wait_idle();
      if (failures == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
sv/bpcm_pkg.sv
sv/bpcm_req_if.sv
sv/bpcm_rsp_if.sv
sv/bpcm_ram.sv
sv/bpcm_ctrl.sv
sv/bpcm_datapath.sv
sv/bit_packer_constellation_mapper.sv
sim/bpcm_tb_pkg.sv
sim/symbol_map_checker.sv
sim/tb.sv
